// File: rtl/core/grid_map_gaussian_splat_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the grid map splat block
// Immediate-consequence and next-cycle property forms, clocked on clk and
// disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef GRID_MAP_GAUSSIAN_SPLAT_ASSERT_SVH
`define GRID_MAP_GAUSSIAN_SPLAT_ASSERT_SVH

// consequence holds in the same cycle as the antecedent
`define GMGS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence holds in the cycle after the antecedent
`define GMGS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/gmgs_pkg.sv
// ---------------------------------------------------------------------------
// gmgs_pkg
// Shared types, register indexes and the Gaussian kernel table of the grid
// map splat block.
// ---------------------------------------------------------------------------
package gmgs_pkg;

	// default map geometry and kernel size
	localparam int MAP_ROWS_DEF    = 256;
	localparam int MAP_COLS_DEF    = 256;
	localparam int KERNEL_HALF_DEF = 3;

	// configuration register indexes
	localparam logic [2:0] CFG_POSE_COL = 3'd0;
	localparam logic [2:0] CFG_POSE_ROW = 3'd1;
	localparam logic [2:0] CFG_ROT_COS  = 3'd2;
	localparam logic [2:0] CFG_ROT_SIN  = 3'd3;
	localparam logic [2:0] CFG_MAP_ROWS = 3'd4;
	localparam logic [2:0] CFG_MAP_COLS = 3'd5;

	// item kinds
	localparam logic KIND_SPLAT = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// cell encoding
	localparam int          CELL_W       = 17;
	localparam logic [16:0] CELL_UNKNOWN = 17'h1FFFF;

	// squared kernel distance width (covers half widths up to 7)
	localparam int KD_W = 7;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic rd_issue;
		logic xf_mul;
		logic xf_sum;
		logic xf_chk;
		logic win_start;
		logic win_step;
		logic clr_step;
		logic out_load;
	} gmgs_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic end_ok;
		logic win_last;
	} gmgs_sts_t;

	// round(65536*exp(-d/2)) saturated to 16 bits, zero from d = 24 on
	function automatic logic [15:0] gauss_lookup(input logic [KD_W-1:0] d);
		logic [15:0] k;
		case (d)
			7'd0:    k = 16'd65535;
			7'd1:    k = 16'd39750;
			7'd2:    k = 16'd24109;
			7'd3:    k = 16'd14623;
			7'd4:    k = 16'd8869;
			7'd5:    k = 16'd5380;
			7'd6:    k = 16'd3263;
			7'd7:    k = 16'd1979;
			7'd8:    k = 16'd1200;
			7'd9:    k = 16'd728;
			7'd10:   k = 16'd442;
			7'd11:   k = 16'd268;
			7'd12:   k = 16'd162;
			7'd13:   k = 16'd99;
			7'd14:   k = 16'd60;
			7'd15:   k = 16'd36;
			7'd16:   k = 16'd22;
			7'd17:   k = 16'd13;
			7'd18:   k = 16'd8;
			7'd19:   k = 16'd5;
			7'd20:   k = 16'd3;
			7'd21:   k = 16'd2;
			7'd22:   k = 16'd1;
			7'd23:   k = 16'd1;
			default: k = 16'd0;
		endcase
		return k;
	endfunction

endpackage

// File: rtl/core/gmgs_ctrl.sv
// ---------------------------------------------------------------------------
// gmgs_ctrl
// Sequencer of the grid map splat block: clearing pass, point transform,
// window sweep, cell read and result hand-off.
// ---------------------------------------------------------------------------
`include "grid_map_gaussian_splat_assert.svh"

module gmgs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	output logic               out_valid,
	input  logic               out_stall,
	output gmgs_pkg::gmgs_cmd_t cmd,
	input  gmgs_pkg::gmgs_sts_t sts
);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_READ  = 4'd2;
	localparam logic [3:0] ST_MUL   = 4'd3;
	localparam logic [3:0] ST_SUM   = 4'd4;
	localparam logic [3:0] ST_CHK   = 4'd5;
	localparam logic [3:0] ST_TEST  = 4'd6;
	localparam logic [3:0] ST_WIN   = 4'd7;
	localparam logic [3:0] ST_DRAIN = 4'd8;
	localparam logic [3:0] ST_PUSH  = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       ovalid_q;
	logic       out_free;

	// output register can take a new item when empty or being drained
	assign out_free  = !ovalid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = ovalid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = (kind == gmgs_pkg::KIND_READ) ? ST_READ : ST_MUL;
				end
			end
			ST_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_PUSH;
			end
			ST_MUL: begin
				cmd.xf_mul = 1'b1;
				state_d    = ST_SUM;
			end
			ST_SUM: begin
				cmd.xf_sum = 1'b1;
				state_d    = ST_CHK;
			end
			ST_CHK: begin
				cmd.xf_chk = 1'b1;
				state_d    = ST_TEST;
			end
			ST_TEST: begin
				if (sts.end_ok) begin
					cmd.win_start = 1'b1;
					state_d       = ST_WIN;
				end else begin
					state_d = ST_PUSH;
				end
			end
			ST_WIN: begin
				cmd.win_step = 1'b1;
				if (sts.win_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			ovalid_q <= 1'b1;
		end else if (!out_stall) begin
			ovalid_q <= 1'b0;
		end
	end

	`GMGS_ASSERT_NXT(a_accept_leaves_idle, in_valid && !in_stall, state_q != ST_IDLE, "accepted item left controller idle")
	`GMGS_ASSERT_IMP(a_no_overwrite, cmd.out_load, !ovalid_q || !out_stall, "pending result overwritten")
	`GMGS_ASSERT_NXT(a_win_drain, state_q == ST_WIN && sts.win_last, state_q == ST_DRAIN, "window sweep did not drain")

endmodule

// File: rtl/core/gmgs_dpath.sv
// ---------------------------------------------------------------------------
// gmgs_dpath
// Datapath of the grid map splat block: configuration registers, point
// transform, window address and kernel generation, likelihood memory with
// read-compare-write pipeline, and the result register.
// ---------------------------------------------------------------------------
`include "grid_map_gaussian_splat_assert.svh"

module gmgs_dpath #(
	parameter int MAP_ROWS    = gmgs_pkg::MAP_ROWS_DEF,
	parameter int MAP_COLS    = gmgs_pkg::MAP_COLS_DEF,
	parameter int KERNEL_HALF = gmgs_pkg::KERNEL_HALF_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [23:0]         cfg_data,
	input  logic                kind,
	input  logic signed [15:0]  point_x,
	input  logic signed [15:0]  point_y,
	input  logic [7:0]          read_row,
	input  logic [7:0]          read_col,
	output logic                in_map,
	output logic [5:0]          cells_raised,
	output logic signed [16:0]  cell_value,
	input  gmgs_pkg::gmgs_cmd_t cmd,
	output gmgs_pkg::gmgs_sts_t sts
);

	localparam int DEPTH = MAP_ROWS * MAP_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(MAP_ROWS);
	localparam int CW    = $clog2(MAP_COLS);
	localparam int KW    = $clog2(KERNEL_HALF + 1) + 1;
	localparam int QW    = 37;
	localparam int HW    = QW - 16;
	localparam int CLW   = gmgs_pkg::CELL_W;
	localparam int KDW   = gmgs_pkg::KD_W;

	// configuration registers
	logic signed [23:0] pose_col_q;
	logic signed [23:0] pose_row_q;
	logic signed [18:0] rot_cos_q;
	logic signed [18:0] rot_sin_q;
	logic [8:0]         map_rows_q;
	logic [8:0]         map_cols_q;

	// captured item
	logic               kind_q;
	logic signed [15:0] px_q;
	logic signed [15:0] py_q;
	logic [7:0]         rr_q;
	logic [7:0]         rc_q;

	// transform pipeline
	logic signed [34:0]   m_cx_s1;
	logic signed [34:0]   m_sy_s1;
	logic signed [34:0]   m_sx_s1;
	logic signed [34:0]   m_cy_s1;
	logic signed [31:0]   pc_sh;
	logic signed [31:0]   pr_sh;
	logic signed [QW-1:0] colq_s2;
	logic signed [QW-1:0] rowq_s2;
	logic [HW-1:0]        col_hi;
	logic [HW-1:0]        row_hi;
	logic                 col_ok;
	logic                 row_ok;
	logic [CW-1:0]        ce_q;
	logic [RW-1:0]        re_q;
	logic                 end_ok_q;

	// window sweep
	logic signed [KW-1:0] di_q;
	logic signed [KW-1:0] dj_q;
	logic signed [CW+1:0] wc;
	logic signed [RW+1:0] wr;
	logic                 w_inmap;
	logic [KW-2:0]        adi;
	logic [KW-2:0]        adj;
	logic [KDW-1:0]       adi7;
	logic [KDW-1:0]       adj7;
	logic [KDW-1:0]       kd;
	logic [AW-1:0]        waddr_c;
	logic [AW-1:0]        addr_s1;
	logic [15:0]          kval_s1;
	logic                 hit_s1;
	logic                 raise;
	logic [5:0]           count_q;

	// memory and read path
	logic [CLW-1:0] grid_mem [DEPTH];
	logic [CLW-1:0] rdata_q;
	logic [AW-1:0]  raddr_c;
	logic [AW-1:0]  rd_addr_c;
	logic           rd_en;
	logic           rd_ok_q;
	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	logic [CLW-1:0] mem_wdata;
	logic [AW-1:0]  clr_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_col_q <= '0;
			pose_row_q <= '0;
			rot_cos_q  <= '0;
			rot_sin_q  <= '0;
			map_rows_q <= 9'd256;
			map_cols_q <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				gmgs_pkg::CFG_POSE_COL: pose_col_q <= cfg_data;
				gmgs_pkg::CFG_POSE_ROW: pose_row_q <= cfg_data;
				gmgs_pkg::CFG_ROT_COS:  rot_cos_q  <= cfg_data[18:0];
				gmgs_pkg::CFG_ROT_SIN:  rot_sin_q  <= cfg_data[18:0];
				gmgs_pkg::CFG_MAP_ROWS: map_rows_q <= cfg_data[8:0];
				gmgs_pkg::CFG_MAP_COLS: map_cols_q <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	// capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			px_q   <= point_x;
			py_q   <= point_y;
			rr_q   <= read_row;
			rc_q   <= read_col;
		end
	end

	// rotate: four products
	always_ff @(posedge clk) begin
		if (cmd.xf_mul) begin
			m_cx_s1 <= rot_cos_q * px_q;
			m_sy_s1 <= rot_sin_q * py_q;
			m_sx_s1 <= rot_sin_q * px_q;
			m_cy_s1 <= rot_cos_q * py_q;
		end
	end

	// translate: pose in Q16.8 lifted to Q.16
	assign pc_sh = {pose_col_q, 8'h00};
	assign pr_sh = {pose_row_q, 8'h00};

	always_ff @(posedge clk) begin
		if (cmd.xf_sum) begin
			colq_s2 <= QW'(pc_sh) + QW'(m_cx_s1) - QW'(m_sy_s1);
			rowq_s2 <= QW'(pr_sh) + QW'(m_sx_s1) + QW'(m_cy_s1);
		end
	end

	// truncate toward zero and test the end cell; a small negative value
	// truncates to cell zero, which needs at least one used row or column;
	// anything at or below -1.0 is outside
	assign col_hi = colq_s2[QW-1:16];
	assign row_hi = rowq_s2[QW-1:16];
	assign col_ok = colq_s2[QW-1] ? ((&col_hi) && (|colq_s2[15:0]) && (|map_cols_q))
		: ((col_hi < HW'(map_cols_q)) && (col_hi < HW'(MAP_COLS)));
	assign row_ok = rowq_s2[QW-1] ? ((&row_hi) && (|rowq_s2[15:0]) && (|map_rows_q))
		: ((row_hi < HW'(map_rows_q)) && (row_hi < HW'(MAP_ROWS)));

	always_ff @(posedge clk) begin
		if (cmd.xf_chk) begin
			ce_q <= colq_s2[QW-1] ? '0 : col_hi[CW-1:0];
			re_q <= rowq_s2[QW-1] ? '0 : row_hi[RW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_ok_q <= 1'b0;
		end else if (cmd.capture) begin
			end_ok_q <= 1'b0;
		end else if (cmd.xf_chk) begin
			end_ok_q <= col_ok && row_ok;
		end
	end

	// advance window offsets, column offset outer, row offset inner
	always_ff @(posedge clk) begin
		if (cmd.win_start) begin
			di_q <= -KW'(KERNEL_HALF);
			dj_q <= -KW'(KERNEL_HALF);
		end else if (cmd.win_step) begin
			if (dj_q == KW'(KERNEL_HALF)) begin
				dj_q <= -KW'(KERNEL_HALF);
				di_q <= di_q + KW'(1);
			end else begin
				dj_q <= dj_q + KW'(1);
			end
		end
	end

	// window cell position and bounds
	assign wc      = $signed({2'b00, ce_q}) + (CW+2)'(di_q);
	assign wr      = $signed({2'b00, re_q}) + (RW+2)'(dj_q);
	assign w_inmap = !wc[CW+1] && !wr[RW+1]
		&& (wc[CW:0] < map_cols_q) && (wc[CW:0] < MAP_COLS)
		&& (wr[RW:0] < map_rows_q) && (wr[RW:0] < MAP_ROWS);
	assign waddr_c = AW'(wr[RW-1:0]) * AW'(MAP_COLS) + AW'(wc[CW-1:0]);

	// kernel value from squared distance
	assign adi  = di_q[KW-1] ? (KW-1)'(-di_q) : di_q[KW-2:0];
	assign adj  = dj_q[KW-1] ? (KW-1)'(-dj_q) : dj_q[KW-2:0];
	assign adi7 = KDW'(adi);
	assign adj7 = KDW'(adj);
	assign kd   = adi7 * adi7 + adj7 * adj7;

	// read stage of the window pipeline
	always_ff @(posedge clk) begin
		addr_s1 <= waddr_c;
		kval_s1 <= gmgs_pkg::gauss_lookup(kd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
		end else begin
			hit_s1 <= cmd.win_step && w_inmap;
		end
	end

	// compare stage: raise the cell when strictly below the kernel
	assign raise = hit_s1 && ($signed(rdata_q) < $signed({1'b0, kval_s1}));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			count_q <= '0;
		end else if (raise && (count_q != 6'd63)) begin
			count_q <= count_q + 6'd1;
		end
	end

	// cell read of a read item
	assign rd_addr_c = AW'(RW'(rr_q)) * AW'(MAP_COLS) + AW'(CW'(rc_q));

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			rd_ok_q <= (rr_q < map_rows_q) && (rr_q < MAP_ROWS)
				&& (rc_q < map_cols_q) && (rc_q < MAP_COLS);
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// memory port selection
	assign raddr_c   = cmd.rd_issue ? rd_addr_c : waddr_c;
	assign rd_en     = cmd.rd_issue || cmd.win_step;
	assign mem_we    = cmd.clr_step || raise;
	assign mem_waddr = cmd.clr_step ? clr_q : addr_s1;
	assign mem_wdata = cmd.clr_step ? gmgs_pkg::CELL_UNKNOWN : {1'b0, kval_s1};

	// likelihood memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_q <= grid_mem[raddr_c];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (kind_q == gmgs_pkg::KIND_READ) begin
				in_map       <= rd_ok_q;
				cells_raised <= '0;
				cell_value   <= rd_ok_q ? $signed(rdata_q) : '0;
			end else begin
				in_map       <= end_ok_q;
				cells_raised <= count_q;
				cell_value   <= '0;
			end
		end
	end

	// status
	assign sts.clr_last = (clr_q == AW'(DEPTH - 1));
	assign sts.end_ok   = end_ok_q;
	assign sts.win_last = (di_q == KW'(KERNEL_HALF)) && (dj_q == KW'(KERNEL_HALF));

	`GMGS_ASSERT_IMP(a_clear_no_raise, cmd.clr_step, !hit_s1, "window write during clearing pass")
	`GMGS_ASSERT_IMP(a_step_in_map, cmd.win_step, end_ok_q, "window sweep for an end cell outside the map")

endmodule

// File: rtl/core/grid_map_gaussian_splat.sv
// ---------------------------------------------------------------------------
// grid_map_gaussian_splat
// Occupancy grid with Gaussian endpoint splatting and single-cell reads.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): kind 0 splats a laser point given
//   in robot-frame millimetres, kind 1 reads the cell at read_row/read_col.
//   Output channel (out_valid / out_stall): one result item per input item,
//   in order: in_map, cells_raised, cell_value.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data):
//   pose, rotation and used map size; write only while the block is idle.
//   Sequence: a read item is captured, its cell read and its result loaded;
//   a splat item is captured, transformed and tested, and when its end cell
//   lies inside the map it sweeps all (2*KERNEL_HALF+1)^2 window cells (49
//   for the default) before its result is loaded. A new item is taken only
//   after the last is loaded. The single read and write port of the memory
//   bounds the sweep to one cell each cycle, read-compare-write pipelined.
//   Reset: a clearing pass sets every one of the MAP_ROWS * MAP_COLS cells
//   (65536 by default) to unknown; in_stall stays high meanwhile.
//   The result register holds while out_stall is high; the next item is
//   accepted and worked on, and waits for the register before its result.
// ---------------------------------------------------------------------------
module grid_map_gaussian_splat #(
	parameter int MAP_ROWS    = gmgs_pkg::MAP_ROWS_DEF,
	parameter int MAP_COLS    = gmgs_pkg::MAP_COLS_DEF,
	parameter int KERNEL_HALF = gmgs_pkg::KERNEL_HALF_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic [7:0]         read_row,
	input  logic [7:0]         read_col,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               in_map,
	output logic [5:0]         cells_raised,
	output logic signed [16:0] cell_value
);

	gmgs_pkg::gmgs_cmd_t cmd;
	gmgs_pkg::gmgs_sts_t sts;
	logic                cfg_we;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	gmgs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	gmgs_dpath #(
		.MAP_ROWS    (MAP_ROWS),
		.MAP_COLS    (MAP_COLS),
		.KERNEL_HALF (KERNEL_HALF)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.kind         (kind),
		.point_x      (point_x),
		.point_y      (point_y),
		.read_row     (read_row),
		.read_col     (read_col),
		.in_map       (in_map),
		.cells_raised (cells_raised),
		.cell_value   (cell_value),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule
